// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ogm_pkg.sv =====
// ----------------------------------------------------------------------------
// ogm_pkg
// Types, constants and helper functions of the orientation gesture matcher.
// ----------------------------------------------------------------------------
package ogm_pkg;

  localparam int MAX_STEPS    = 256;
  localparam int ANGLE_LEVELS = 19;
  localparam int LEVEL_W      = 5;
  localparam int SMP_W        = 3 * LEVEL_W;
  localparam int ADDR_W       = $clog2(MAX_STEPS);
  localparam int STEP_W       = $clog2(MAX_STEPS + 1);
  localparam int TOL_W        = 5;
  localparam int STRIKE_W     = 4;
  localparam int CFG_W        = 5;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(ANGLE_LEVELS - 1);
  localparam logic [STEP_W-1:0]  STEPS_CAP = STEP_W'(MAX_STEPS);

  localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(2);
  localparam logic [STRIKE_W-1:0] STRIKE_RESET = STRIKE_W'(2);

  typedef enum logic {
    CFG_TOLERANCE    = 1'b0,
    CFG_STRIKE_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_REC_START   = 2'd0,
    MODE_REC_SAMPLE  = 2'd1,
    MODE_MATCH_START = 2'd2,
    MODE_MATCH_SAMPLE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_REC   = 2'd1,
    PH_MATCH = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EXEC = 2'd2,
    ST_RESP = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic exec;
  } ctrl_cmd_t;

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
    sat_level = (v > LEVEL_MAX) ? LEVEL_MAX : v;
  endfunction

  function automatic logic axis_close(input logic [LEVEL_W-1:0] a,
                                      input logic [LEVEL_W-1:0] b,
                                      input logic [TOL_W-1:0] tol);
    logic [LEVEL_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    axis_close = (TOL_W'(d) <= tol);
  endfunction

  function automatic logic sample_hit(input logic [SMP_W-1:0] want,
                                      input logic [SMP_W-1:0] got,
                                      input logic [TOL_W-1:0] tol);
    sample_hit = axis_close(want[LEVEL_W-1:0], got[LEVEL_W-1:0], tol)
              && axis_close(want[2*LEVEL_W-1:LEVEL_W], got[2*LEVEL_W-1:LEVEL_W], tol)
              && axis_close(want[3*LEVEL_W-1:2*LEVEL_W], got[3*LEVEL_W-1:2*LEVEL_W], tol);
  endfunction

endpackage

// ===== src/ogm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ogm_ctrl
// Sequencer: accepts a transaction, steps the datapath through template read,
// update and result strobe.
// ----------------------------------------------------------------------------
module ogm_ctrl import ogm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ogm_datapath.sv =====
// ----------------------------------------------------------------------------
// ogm_datapath
// Template store, configuration, recording and matching state.
// ----------------------------------------------------------------------------
module ogm_datapath import ogm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [1:0]          mode,
  input  logic [LEVEL_W-1:0]  roll_level,
  input  logic [LEVEL_W-1:0]  pitch_level,
  input  logic [LEVEL_W-1:0]  yaw_level,
  input  logic                stop,
  output logic                accepted,
  output logic [1:0]          phase,
  output logic [STEP_W-1:0]   progress,
  output logic [STRIKE_W-1:0] strike_count,
  output logic [STEP_W-1:0]   template_length,
  output logic                matched,
  output logic                aborted,
  output logic                store_full
);

  logic [SMP_W-1:0] mem [MAX_STEPS];
  logic [SMP_W-1:0] rd_data;

  logic [TOL_W-1:0]    tolerance;
  logic [STRIKE_W-1:0] strike_limit;

  mode_t               cur_mode;
  logic                cur_stop;
  logic [SMP_W-1:0]    smp;
  logic [STEP_W-1:0]   count;
  logic [SMP_W-1:0]    last;
  logic [STEP_W-1:0]   prog;
  logic [STRIKE_W-1:0] misses;
  phase_t              ph;
  logic                acc;
  logic                full;

  logic              changed;
  logic              room;
  logic              mem_we;
  logic [STEP_W-1:0] prog_inc;
  logic              hit;

  assign changed  = (smp != last);
  assign room     = (count < STEPS_CAP);
  assign prog_inc = prog + STEP_W'(1);
  assign hit      = sample_hit(rd_data, smp, tolerance);
  assign mem_we   = cmd.exec && (cur_mode == MODE_REC_SAMPLE) && (ph == PH_REC)
                 && !cur_stop && changed && room;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[ADDR_W-1:0]] <= smp;
    end
    if (cmd.read) begin
      rd_data <= mem[prog[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance    <= TOL_RESET;
      strike_limit <= STRIKE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_TOLERANCE:    tolerance    <= cfg_data[TOL_W-1:0];
        CFG_STRIKE_LIMIT: strike_limit <= cfg_data[STRIKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_mode <= mode_t'(mode);
      cur_stop <= stop;
      smp      <= {sat_level(yaw_level), sat_level(pitch_level), sat_level(roll_level)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      last   <= '0;
      prog   <= '0;
      misses <= '0;
      ph     <= PH_IDLE;
      acc    <= 1'b0;
      full   <= 1'b0;
    end else if (cmd.exec) begin
      acc  <= 1'b0;
      full <= 1'b0;
      case (cur_mode)
        MODE_REC_START: begin
          count  <= '0;
          last   <= '0;
          prog   <= '0;
          misses <= '0;
          ph     <= PH_REC;
        end
        MODE_MATCH_START: begin
          last   <= '0;
          prog   <= '0;
          misses <= '0;
          ph     <= (count == '0) ? PH_DONE : PH_MATCH;
        end
        MODE_REC_SAMPLE: begin
          if (ph == PH_REC) begin
            if (cur_stop) begin
              ph <= PH_IDLE;
            end else if (changed) begin
              if (room) begin
                count <= count + STEP_W'(1);
                last  <= smp;
                acc   <= 1'b1;
              end else begin
                full <= 1'b1;
              end
            end
          end
        end
        MODE_MATCH_SAMPLE: begin
          if (ph == PH_MATCH) begin
            if (cur_stop) begin
              ph <= PH_DONE;
            end else if (changed) begin
              acc  <= 1'b1;
              last <= smp;
              if (hit) begin
                prog <= prog_inc;
                if (prog_inc >= count) begin
                  ph <= PH_DONE;
                end
              end else if (misses >= strike_limit) begin
                prog   <= '0;
                misses <= '0;
              end else begin
                misses <= misses + STRIKE_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign accepted        = acc;
  assign phase           = ph;
  assign progress        = prog;
  assign strike_count    = misses;
  assign template_length = count;
  assign matched         = (ph == PH_DONE) && (prog >= count);
  assign aborted         = (ph == PH_DONE) && (prog < count);
  assign store_full      = full;

endmodule

// ===== src/orientation_gesture_matcher.sv =====
// ----------------------------------------------------------------------------
// orientation_gesture_matcher
// Records a gesture as a sequence of quantized orientation samples and matches
// a live sample stream against it.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low; the
//   mode, level and stop ports are sampled there. busy stays high after it,
//   through the done cycle, while the template entry at the current progress
//   is read from the single-port store and the state is updated.
//   done is high for one cycle, in the respond state after the update, with
//   the result on accepted, phase, progress, strike_count, template_length,
//   matched, aborted and store_full. A new transaction is taken only once the
//   read/update/respond sequence around the registered store read has ended.
//   The receiver cannot stall; each result stays on the outputs until the next update.
//   Configuration: cfg_we with cfg_index 0 (tolerance) or 1 (strike limit)
//   and cfg_data, written at once; only while busy is low, which the user must keep to and the block does not enforce.
//   Reset (rst, synchronous) returns to idle with an empty template,
//   tolerance 2 and strike limit 2. The store itself is not cleared.
// ----------------------------------------------------------------------------
module orientation_gesture_matcher import ogm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [1:0]          mode,
  input  logic [LEVEL_W-1:0]  roll_level,
  input  logic [LEVEL_W-1:0]  pitch_level,
  input  logic [LEVEL_W-1:0]  yaw_level,
  input  logic                stop,
  output logic                accepted,
  output logic [1:0]          phase,
  output logic [STEP_W-1:0]   progress,
  output logic [STRIKE_W-1:0] strike_count,
  output logic [STEP_W-1:0]   template_length,
  output logic                matched,
  output logic                aborted,
  output logic                store_full
);

  ctrl_cmd_t cmd;

  ogm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ogm_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .roll_level      (roll_level),
    .pitch_level     (pitch_level),
    .yaw_level       (yaw_level),
    .stop            (stop),
    .accepted        (accepted),
    .phase           (phase),
    .progress        (progress),
    .strike_count    (strike_count),
    .template_length (template_length),
    .matched         (matched),
    .aborted         (aborted),
    .store_full      (store_full)
  );

endmodule

// ===== src/ogm_checker.sv =====
// ----------------------------------------------------------------------------
// ogm_checker
// Port-level checks of the orientation gesture matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ogm_checker import ogm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic                accepted,
  input logic [1:0]          phase,
  input logic [STEP_W-1:0]   progress,
  input logic [STEP_W-1:0]   template_length,
  input logic                matched,
  input logic                aborted,
  input logic                store_full
);

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy low after accepted transaction")
  `ASSERT_IMPLY(a_acc_full_excl, clk, rst, done, !(accepted && store_full), "accepted and store_full together")
  `ASSERT_IMPLY(a_end_excl, clk, rst, done, !(matched && aborted), "matched and aborted together")
  `ASSERT_IMPLY(a_end_phase, clk, rst, done && (matched || aborted), phase == PH_DONE, "end flag outside finished phase")
  `ASSERT_IMPLY(a_prog_bound, clk, rst, done && (phase == PH_MATCH), progress < template_length, "progress past template while matching")

endmodule

bind orientation_gesture_matcher ogm_checker u_ogm_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .accepted        (accepted),
  .phase           (phase),
  .progress        (progress),
  .template_length (template_length),
  .matched         (matched),
  .aborted         (aborted),
  .store_full      (store_full)
);
